FILE: rtl/core/brc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_pkg
// Shared types and constants for the corner-based target range estimator.
// ----------------------------------------------------------------------------
package brc_pkg;

	localparam int TAN_BITS   = 18;
	localparam int DIST_BITS  = 16;
	localparam int SIZE_BITS  = 13;
	localparam int TERM_BITS  = 32;
	localparam int OFFS_BITS  = 31;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 18;
	localparam int LANES      = 4;

	localparam logic [CFG_IDX_BITS-1:0] REG_TAN_H  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TAN_V  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_DIST   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd4;

	localparam logic [TAN_BITS-1:0]  RST_TAN_H  = 18'd50285;
	localparam logic [TAN_BITS-1:0]  RST_TAN_V  = 18'd27146;
	localparam logic [DIST_BITS-1:0] RST_DIST   = 16'd2515;
	localparam logic [SIZE_BITS-1:0] RST_WIDTH  = 13'd640;
	localparam logic [SIZE_BITS-1:0] RST_HEIGHT = 13'd480;

	typedef struct packed {
		logic [TAN_BITS-1:0]  tan_h;
		logic [TAN_BITS-1:0]  tan_v;
		logic [DIST_BITS-1:0] corner_dist;
		logic [SIZE_BITS-1:0] width;
		logic [SIZE_BITS-1:0] height;
	} brc_cfg_t;

	typedef struct packed {
		logic [TERM_BITS-1:0] term;
		logic                 flag;
	} brc_res_t;

endpackage

FILE: rtl/core/brc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module brc_div #(
	parameter int NW = 31,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int NP  = NW + (NW % 2);
	localparam int CYC = NP / 2;
	localparam int CW  = (CYC > 1) ? $clog2(CYC) : 1;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   rem_q;
	logic [NP-1:0] nq_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_d;
	logic [NP-1:0] nq_d;

	always_comb begin
		rem_d = rem_q;
		nq_d  = nq_q;
		for (int i = 0; i < 2; i++) begin
			rem_d = {rem_d[DW-1:0], nq_d[NP-1]};
			nq_d  = {nq_d[NP-2:0], 1'b0};
			if (rem_d >= {1'b0, den_q}) begin
				rem_d    = rem_d - {1'b0, den_q};
				nq_d[0]  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(CYC - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q  <= NP'(num);
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_d;
			nq_q  <= nq_d;
		end
	end

	assign done = done_q;
	assign quo  = nq_q[NW-1:0];

endmodule

FILE: rtl/core/brc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_sqrt
// Iterative integer square root (floor), two root bits per cycle.
// ----------------------------------------------------------------------------
module brc_sqrt #(
	parameter int IW = 63
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [IW-1:0]         rad,
	output logic                  done,
	output logic [(IW+1)/2-1:0]   root
);

	localparam int RW  = (IW + 1) / 2;
	localparam int RP  = RW + (RW % 2);
	localparam int XP  = 2 * RP;
	localparam int CYC = RP / 2;
	localparam int CW  = (CYC > 1) ? $clog2(CYC) : 1;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [XP-1:0] x_q;
	logic [RP:0]   rem_q;
	logic [RP-1:0] root_q;
	logic [XP-1:0] x_d;
	logic [RP+2:0] acc;
	logic [RP+2:0] trial;
	logic [RP:0]   rem_d;
	logic [RP-1:0] root_d;

	always_comb begin
		x_d    = x_q;
		rem_d  = rem_q;
		root_d = root_q;
		acc    = '0;
		trial  = '0;
		for (int i = 0; i < 2; i++) begin
			acc   = {rem_d, x_d[XP-1:XP-2]};
			x_d   = {x_d[XP-3:0], 2'b00};
			trial = {1'b0, root_d, 2'b01};
			if (acc >= trial) begin
				acc    = acc - trial;
				root_d = {root_d[RP-2:0], 1'b1};
			end else begin
				root_d = {root_d[RP-2:0], 1'b0};
			end
			rem_d = acc[RP:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(CYC - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= XP'(rad);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_d;
			rem_q  <= rem_d;
			root_q <= root_d;
		end
	end

	assign done = done_q;
	assign root = root_q[RW-1:0];

endmodule

FILE: rtl/core/brc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_lane
// One corner: angular offsets, squared length, root and range term.
// ----------------------------------------------------------------------------
module brc_lane #(
	parameter int COORD_BITS    = 12,
	parameter int TAN_FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  brc_pkg::brc_cfg_t       cfg,
	input  logic [COORD_BITS-1:0]   cx,
	input  logic [COORD_BITS-1:0]   cy,
	input  logic [COORD_BITS-1:0]   px,
	input  logic [COORD_BITS-1:0]   py,
	output logic                    done,
	output brc_pkg::brc_res_t       res
);

	localparam int OB  = brc_pkg::OFFS_BITS;
	localparam int TB  = brc_pkg::TERM_BITS;
	localparam int NW  = COORD_BITS + 1 + brc_pkg::TAN_BITS;
	localparam int NX  = (NW > OB) ? NW : OB;
	localparam int SW  = 2 * OB + 1;
	localparam int RW  = (SW + 1) / 2;
	localparam int QW  = brc_pkg::DIST_BITS + TAN_FRAC_BITS;
	localparam int QX  = (QW > TB) ? QW : TB;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OFFS = 3'd1;
	localparam logic [2:0] ST_SQR  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_QUO  = 3'd5;

	logic [2:0]              state_q;
	logic [COORD_BITS-1:0]   dx;
	logic [COORD_BITS-1:0]   dy;
	logic [NW-1:0]           num_u;
	logic [NW-1:0]           num_v;
	logic [brc_pkg::SIZE_BITS-1:0] den_u;
	logic [brc_pkg::SIZE_BITS-1:0] den_v;
	logic                    du_done;
	logic                    dv_done;
	logic [NW-1:0]           u_raw;
	logic [NW-1:0]           v_raw;
	logic [OB-1:0]           u_c;
	logic [OB-1:0]           v_c;
	logic [2*OB-1:0]         uu_q;
	logic [2*OB-1:0]         vv_q;
	logic [SW-1:0]           s_sum;
	logic                    sq_start;
	logic                    sq_done;
	logic [RW-1:0]           r;
	logic                    q_start;
	logic                    q_done;
	logic [QW-1:0]           q_raw;
	logic [QX-1:0]           q_ext;
	logic                    done_q;
	brc_pkg::brc_res_t       res_q;

	assign dx    = (px >= cx) ? px - cx : cx - px;
	assign dy    = (py >= cy) ? py - cy : cy - py;
	assign num_u = NW'({dx, 1'b0} * cfg.tan_h);
	assign num_v = NW'({dy, 1'b0} * cfg.tan_v);
	assign den_u = (cfg.width == '0) ? brc_pkg::SIZE_BITS'(1) : cfg.width;
	assign den_v = (cfg.height == '0) ? brc_pkg::SIZE_BITS'(1) : cfg.height;

	brc_div #(.NW(NW), .DW(brc_pkg::SIZE_BITS)) u_div_u (
		.clk(clk), .arst_n(arst_n), .start(start),
		.num(num_u), .den(den_u), .done(du_done), .quo(u_raw)
	);

	brc_div #(.NW(NW), .DW(brc_pkg::SIZE_BITS)) u_div_v (
		.clk(clk), .arst_n(arst_n), .start(start),
		.num(num_v), .den(den_v), .done(dv_done), .quo(v_raw)
	);

	always_comb begin
		logic [NX-1:0] ue;
		logic [NX-1:0] ve;
		ue  = NX'(u_raw);
		ve  = NX'(v_raw);
		u_c = (ue > NX'({OB{1'b1}})) ? {OB{1'b1}} : ue[OB-1:0];
		v_c = (ve > NX'({OB{1'b1}})) ? {OB{1'b1}} : ve[OB-1:0];
	end

	assign s_sum    = SW'(uu_q) + SW'(vv_q);
	assign sq_start = (state_q == ST_SUM) && (s_sum != '0);

	brc_sqrt #(.IW(SW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.rad(s_sum), .done(sq_done), .root(r)
	);

	assign q_start = (state_q == ST_ROOT) && sq_done;

	brc_div #(.NW(QW), .DW(RW)) u_div_q (
		.clk(clk), .arst_n(arst_n), .start(q_start),
		.num(QW'(cfg.corner_dist) << TAN_FRAC_BITS), .den(r), .done(q_done), .quo(q_raw)
	);

	assign q_ext = QX'(q_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_OFFS;
				end
				ST_OFFS: begin
					if (du_done && dv_done) state_q <= ST_SQR;
				end
				ST_SQR: state_q <= ST_SUM;
				ST_SUM: begin
					if (s_sum == '0) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (sq_done) state_q <= ST_QUO;
				end
				ST_QUO: begin
					if (q_done) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OFFS) begin
			uu_q <= u_c * u_c;
			vv_q <= v_c * v_c;
		end
		if (state_q == ST_SUM && s_sum == '0) begin
			res_q.term <= {TB{1'b1}};
			res_q.flag <= 1'b1;
		end else if (state_q == ST_QUO && q_done) begin
			if (q_ext > QX'({TB{1'b1}})) begin
				res_q.term <= {TB{1'b1}};
				res_q.flag <= 1'b1;
			end else begin
				res_q.term <= q_ext[TB-1:0];
				res_q.flag <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: rtl/core/barcode_range_from_corners.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barcode_range_from_corners
// Range to a square target from its center and four corner pixel positions.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries the target center and four corners. It is held in an
//   input register and launched into four corner lanes that run in parallel;
//   a merge stage sums the four range terms, divides by four and ORs the
//   degenerate flags into an output register.
//   Each lane runs two offset dividers, a squaring stage, a root unit and a
//   range divider; the dividers and the root unit are iterative at two bits
//   per cycle. The lanes take a new item only after the last one has been
//   merged into the output register.
//   A corner equal to the center finishes early with a saturated term.
//   The input register takes the next request while the lanes work, and the
//   output register holds a result while out_ready is low; the lanes then
//   keep their finished terms until the output register frees.
//   The user must write configuration through cfg_we/cfg_addr/cfg_wdata
//   only while the block is idle; the block itself does not enforce this.
//   Reset loads the default camera and target values and empties every stage.
// ----------------------------------------------------------------------------
module barcode_range_from_corners #(
	parameter int COORD_BITS    = 12,
	parameter int TAN_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [brc_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
	input  logic [brc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [COORD_BITS-1:0]               center_x,
	input  logic [COORD_BITS-1:0]               center_y,
	input  logic [COORD_BITS-1:0]               corner1_x,
	input  logic [COORD_BITS-1:0]               corner1_y,
	input  logic [COORD_BITS-1:0]               corner2_x,
	input  logic [COORD_BITS-1:0]               corner2_y,
	input  logic [COORD_BITS-1:0]               corner3_x,
	input  logic [COORD_BITS-1:0]               corner3_y,
	input  logic [COORD_BITS-1:0]               corner4_x,
	input  logic [COORD_BITS-1:0]               corner4_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [brc_pkg::TERM_BITS-1:0]       range_estimate,
	output logic                                degenerate
);

	localparam int NL = brc_pkg::LANES;
	localparam int TB = brc_pkg::TERM_BITS;

	brc_pkg::brc_cfg_t       cfg_q;
	logic                    hold_vld_q;
	logic [COORD_BITS-1:0]   hx_q [NL+1];
	logic [COORD_BITS-1:0]   hy_q [NL+1];
	logic                    busy_q;
	logic [NL-1:0]           fin_q;
	logic [NL-1:0]           lane_done;
	brc_pkg::brc_res_t       lane_res [NL];
	logic                    launch;
	logic                    merge;
	logic                    accept;
	logic [TB+1:0]           sum;
	logic                    any_flag;
	logic                    out_vld_q;
	logic [TB-1:0]           range_q;
	logic                    flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tan_h       <= brc_pkg::RST_TAN_H;
			cfg_q.tan_v       <= brc_pkg::RST_TAN_V;
			cfg_q.corner_dist <= brc_pkg::RST_DIST;
			cfg_q.width       <= brc_pkg::RST_WIDTH;
			cfg_q.height      <= brc_pkg::RST_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_addr)
				brc_pkg::REG_TAN_H:  cfg_q.tan_h  <= cfg_wdata[brc_pkg::TAN_BITS-1:0];
				brc_pkg::REG_TAN_V:  cfg_q.tan_v  <= cfg_wdata[brc_pkg::TAN_BITS-1:0];
				brc_pkg::REG_DIST:   cfg_q.corner_dist <= cfg_wdata[brc_pkg::DIST_BITS-1:0];
				brc_pkg::REG_WIDTH:  cfg_q.width  <= cfg_wdata[brc_pkg::SIZE_BITS-1:0];
				brc_pkg::REG_HEIGHT: cfg_q.height <= cfg_wdata[brc_pkg::SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !hold_vld_q;
	assign accept   = in_valid && in_ready;
	assign launch   = hold_vld_q && !busy_q;
	assign merge    = busy_q && (&fin_q) && (!out_vld_q || out_ready);

	always_ff @(posedge clk) begin
		if (accept) begin
			hx_q[0] <= center_x;   hy_q[0] <= center_y;
			hx_q[1] <= corner1_x;  hy_q[1] <= corner1_y;
			hx_q[2] <= corner2_x;  hy_q[2] <= corner2_y;
			hx_q[3] <= corner3_x;  hy_q[3] <= corner3_y;
			hx_q[4] <= corner4_x;  hy_q[4] <= corner4_y;
		end
	end

	for (genvar g = 0; g < NL; g++) begin : g_lane
		brc_lane #(.COORD_BITS(COORD_BITS), .TAN_FRAC_BITS(TAN_FRAC_BITS)) u_lane (
			.clk(clk), .arst_n(arst_n), .start(launch), .cfg(cfg_q),
			.cx(hx_q[0]), .cy(hy_q[0]), .px(hx_q[g+1]), .py(hy_q[g+1]),
			.done(lane_done[g]), .res(lane_res[g])
		);
	end

	always_comb begin
		sum      = '0;
		any_flag = 1'b0;
		for (int i = 0; i < NL; i++) begin
			sum      = sum + (TB+2)'(lane_res[i].term);
			any_flag = any_flag | lane_res[i].flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			busy_q     <= 1'b0;
			fin_q      <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (accept) hold_vld_q <= 1'b1;
			else if (launch) hold_vld_q <= 1'b0;
			if (launch) begin
				busy_q <= 1'b1;
				fin_q  <= '0;
			end else begin
				if (merge) busy_q <= 1'b0;
				fin_q <= fin_q | lane_done;
			end
			if (merge) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (merge) begin
			range_q <= sum[TB+1:2];
			flag_q  <= any_flag;
		end
	end

	assign out_valid      = out_vld_q;
	assign range_estimate = range_q;
	assign degenerate     = flag_q;

`ifndef SYNTH
	a_launch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		launch |-> (fin_q == '0 || !busy_q))
		else $error("launch while lanes busy");
	a_merge_all: assert property (@(posedge clk) disable iff (!arst_n)
		merge |=> !busy_q && out_valid)
		else $error("merge did not free lanes");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(|lane_done) |-> busy_q)
		else $error("lane finished with no item in flight");
`endif

endmodule
